/* design/bba_pkg.sv */
`default_nettype none

package bba_pkg;

    // Operation codes carried in the opcode field of an input word.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Number of axes of a point.
    localparam int NUM_AXES = 3;

endpackage

`default_nettype wire

/* design/bba_sumsq.sv */
`default_nettype none

// Sum of the squared axis sizes, one shared multiplier stepped over the axes.
module bba_sumsq
    import bba_pkg::*;
#(
    parameter int W = 24
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [W-1:0]         size [NUM_AXES],
    output logic                      done,
    output logic [2*W+1:0]            sum
);

    logic [1:0]       idx_reg, idx_next;
    logic             run_reg, run_next;
    logic             mul_valid_reg, mul_valid_next;
    logic             done_reg, done_next;
    logic [2*W-1:0]   prod_reg, prod_next;
    logic [2*W+1:0]   acc_reg, acc_next;
    logic [W-1:0]     size_sel;

    always_comb
    begin
        case (idx_reg)
            2'd0:    size_sel = size[0];
            2'd1:    size_sel = size[1];
            default: size_sel = size[2];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        run_next       = run_reg;
        mul_valid_next = 1'b0;
        done_next      = mul_valid_reg && !run_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;

        if (mul_valid_reg)
        begin
            acc_next = acc_reg + (2*W+2)'(prod_reg);
        end

        if (run_reg)
        begin
            prod_next      = (2*W)'(size_sel) * (2*W)'(size_sel);
            mul_valid_next = 1'b1;
            idx_next       = idx_reg + 2'd1;
            if (idx_reg == 2'(NUM_AXES - 1))
            begin
                run_next = 1'b0;
            end
        end

        if (start)
        begin
            idx_next       = 2'd0;
            run_next       = 1'b1;
            mul_valid_next = 1'b0;
            done_next      = 1'b0;
            acc_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            run_reg       <= 1'b0;
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            run_reg       <= run_next;
            mul_valid_reg <= mul_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

/* design/bba_sqrt.sv */
`default_nettype none

// Restoring integer square root, one result bit per cycle.
module bba_sqrt
#(
    parameter int RW = 25
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [2*RW-1:0]    radicand,
    output logic                    done,
    output logic [RW-1:0]           root
);

    logic [2*RW-1:0] n_reg, n_next;
    logic [2*RW-1:0] root_reg, root_next;
    logic [2*RW-1:0] bit_reg, bit_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [2*RW:0]   trial;
    logic            fits;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, n_reg} >= trial;

    always_comb
    begin
        n_next    = n_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (run_reg)
        begin
            if (fits)
            begin
                n_next    = n_reg - trial[2*RW-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end

        if (start)
        begin
            n_next    = radicand;
            root_next = '0;
            bit_next  = (2*RW)'(1) << (2*RW - 2);
            run_next  = 1'b1;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[RW-1:0];

endmodule

`default_nettype wire

/* design/bounding_box_accumulator.sv */
`default_nettype none

// Running axis-aligned 3D bounding box over signed Q16.8 points. Each input
// word either adds a point (opcode 0) or empties the box (opcode 1), and
// produces exactly one result word: the changed and valid flags, both
// corners, the per-axis size and the truncated diagonal length. While the
// box is empty every corner, size and length field reads as zero. An add
// goes through these steps from acceptance until its result is in the
// output register and the next word can be accepted: launch, the shared
// multiplier that squares the three sizes and sums them, the start of the
// root unit, the restoring square root that yields one bit of the length
// per cycle, the sequencer seeing the root finish, and the load of the
// result register. A clear skips the arithmetic and goes straight to the
// load of the result register. The block holds point_stall high from
// acceptance until the result is loaded into the output register; a result
// that waits there does not block the next word from being accepted, but it
// delays the load of the next result.
module bounding_box_accumulator
    import bba_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           point_valid,
    output logic                                point_stall,
    input  wire logic                           opcode,
    input  wire logic signed [COORD_WIDTH-1:0]  point_x,
    input  wire logic signed [COORD_WIDTH-1:0]  point_y,
    input  wire logic signed [COORD_WIDTH-1:0]  point_z,

    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic                                changed,
    output logic                                valid_res,
    output logic signed [COORD_WIDTH-1:0]       min_x,
    output logic signed [COORD_WIDTH-1:0]       min_y,
    output logic signed [COORD_WIDTH-1:0]       min_z,
    output logic signed [COORD_WIDTH-1:0]       max_x,
    output logic signed [COORD_WIDTH-1:0]       max_y,
    output logic signed [COORD_WIDTH-1:0]       max_z,
    output logic [COORD_WIDTH-1:0]              size_x,
    output logic [COORD_WIDTH-1:0]              size_y,
    output logic [COORD_WIDTH-1:0]              size_z,
    output logic [COORD_WIDTH:0]                diag_length
);

    localparam int W = COORD_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SQ    = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic                   box_valid_reg, box_valid_next;
    logic                   changed_reg, changed_next;
    logic signed [W-1:0]    box_low_reg  [NUM_AXES];
    logic signed [W-1:0]    box_low_next [NUM_AXES];
    logic signed [W-1:0]    box_high_reg  [NUM_AXES];
    logic signed [W-1:0]    box_high_next [NUM_AXES];
    logic signed [W-1:0]    point [NUM_AXES];
    logic [W-1:0]           size [NUM_AXES];

    logic                   result_valid_reg, result_valid_next;
    logic                   changed_out_reg;
    logic                   valid_out_reg;
    logic signed [W-1:0]    min_out_reg [NUM_AXES];
    logic signed [W-1:0]    max_out_reg [NUM_AXES];
    logic [W-1:0]           size_out_reg [NUM_AXES];
    logic [W:0]             diag_out_reg;
    logic                   load_out;

    logic                   accept;
    logic                   sq_start;
    logic                   sq_done;
    logic [2*W+1:0]         sq_sum;
    logic                   root_done;
    logic [W:0]             root;

    assign point[0] = point_x;
    assign point[1] = point_y;
    assign point[2] = point_z;

    assign point_stall = (state_reg != S_IDLE);
    assign accept      = point_valid && !point_stall;

    // Sizes always follow the stored corners; high never falls below low.
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            size[i] = W'(box_high_reg[i] - box_low_reg[i]);
        end
    end

    // Corner update on acceptance. The first point after reset or a clear
    // seeds both corners; later points widen one bound per axis at most.
    always_comb
    begin
        box_valid_next = box_valid_reg;
        changed_next   = changed_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            box_low_next[i]  = box_low_reg[i];
            box_high_next[i] = box_high_reg[i];
        end

        if (accept)
        begin
            if (opcode == OP_CLEAR)
            begin
                box_valid_next = 1'b0;
                changed_next   = 1'b0;
            end
            else if (!box_valid_reg)
            begin
                box_valid_next = 1'b1;
                changed_next   = 1'b1;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    box_low_next[i]  = point[i];
                    box_high_next[i] = point[i];
                end
            end
            else
            begin
                changed_next = 1'b0;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    if (point[i] < box_low_reg[i])
                    begin
                        box_low_next[i] = point[i];
                        changed_next    = 1'b1;
                    end
                    else if (point[i] > box_high_reg[i])
                    begin
                        box_high_next[i] = point[i];
                        changed_next     = 1'b1;
                    end
                end
            end
        end
    end

    // Sequencer: for an add, corners, then sum of squares, then square root, then
    // the output register as soon as it is free; a clear goes straight to it.
    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        load_out   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_CLEAR)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                sq_start   = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (sq_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (load_out)
        begin
            result_valid_next = 1'b1;
        end
    end

    bba_sumsq #(
        .W (W)
    ) u_sumsq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .size  (size),
        .done  (sq_done),
        .sum   (sq_sum)
    );

    // The root unit starts on the cycle the sum becomes available.
    bba_sqrt #(
        .RW (W + 1)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_done),
        .radicand (sq_sum),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            box_valid_reg    <= 1'b0;
            changed_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_low_reg[i]  <= '0;
                box_high_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            box_valid_reg    <= box_valid_next;
            changed_reg      <= changed_next;
            result_valid_reg <= result_valid_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_low_reg[i]  <= box_low_next[i];
                box_high_reg[i] <= box_high_next[i];
            end
        end
    end

    // Result register; an empty box reports zero in every numeric field.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            changed_out_reg <= changed_reg;
            valid_out_reg   <= box_valid_reg;
            diag_out_reg    <= box_valid_reg ? root : '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                min_out_reg[i]  <= box_valid_reg ? box_low_reg[i]  : '0;
                max_out_reg[i]  <= box_valid_reg ? box_high_reg[i] : '0;
                size_out_reg[i] <= box_valid_reg ? size[i]         : '0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign changed      = changed_out_reg;
    assign valid_res    = valid_out_reg;
    assign min_x        = min_out_reg[0];
    assign min_y        = min_out_reg[1];
    assign min_z        = min_out_reg[2];
    assign max_x        = max_out_reg[0];
    assign max_y        = max_out_reg[1];
    assign max_z        = max_out_reg[2];
    assign size_x       = size_out_reg[0];
    assign size_y       = size_out_reg[1];
    assign size_z       = size_out_reg[2];
    assign diag_length  = diag_out_reg;

endmodule

`default_nettype wire
